[rtl/ordered_key_value_multimap_macros.svh]
// Assertion macros for the ordered key-value multimap.
// Used by the top level only; expects clk and rst_n in the including scope.
`ifndef ORDERED_KEY_VALUE_MULTIMAP_MACROS_SVH
`define ORDERED_KEY_VALUE_MULTIMAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OKVM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OKVM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/okvm_pkg.sv]
// Shared types, sizes and codes for the ordered key-value multimap.
// No dependencies; used by every module of the block.
package okvm_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int PCOUNT_W = 5;

  // Stream data widths, padded to whole bytes.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  // Command queue between front and back (power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Command codes on the input.
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_VALUE     = 2'd3;

  // Operation kind after classification by the front end.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_SEARCH,
    OP_NOP
  } op_t;

  // Queued operation handed from front to back.
  typedef struct packed {
    op_t               kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } item_t;

  // One stored pair.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } pair_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } bk_state_t;

  // Map a raw command code to an operation kind.
  function automatic op_t decode_cmd(input logic [CMD_W-1:0] cmd);
    op_t kind;
    case (cmd)
      CMD_ADD:    kind = OP_ADD;
      CMD_REMOVE: kind = OP_REMOVE;
      CMD_SEARCH: kind = OP_SEARCH;
      default:    kind = OP_NOP;
    endcase
    return kind;
  endfunction

endpackage

[rtl/okvm_front.sv]
// Front end of the multimap: accepts input transactions, decodes the
// command and holds operations in a short queue. Depends on okvm_pkg.
module okvm_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] cmd, [33:2] key, [65:34] value, [71:66] zero
  input  logic [okvm_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             q_valid,
  output okvm_pkg::item_t                  q_item,
  input  logic                             q_pop
);

  okvm_pkg::item_t                   q_mem_r [okvm_pkg::QUEUE_DEPTH];
  logic [okvm_pkg::Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [okvm_pkg::Q_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [okvm_pkg::Q_CNT_W-1:0]      fill_r, fill_nxt;
  okvm_pkg::item_t                   push_item;
  logic                              push;
  logic                              pop;

  // Unpack and classify the incoming transaction.
  always_comb begin
    push_item.kind  = okvm_pkg::decode_cmd(in_tdata[okvm_pkg::CMD_W-1:0]);
    push_item.key   = in_tdata[okvm_pkg::CMD_W +: okvm_pkg::KEY_W];
    push_item.value = in_tdata[okvm_pkg::CMD_W + okvm_pkg::KEY_W +: okvm_pkg::VAL_W];
  end

  // Handshake and queue bookkeeping.
  assign in_tready = (fill_r != okvm_pkg::Q_CNT_W'(okvm_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/okvm_back.sv]
// Back end of the multimap: pair memory, entry count, scan and close-up
// sequencer, and the result output register. Depends on okvm_pkg.
module okvm_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  okvm_pkg::item_t                    q_item,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [33:2] found_value, [38:34] pair_count, [39] zero
  output logic [okvm_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  output logic [okvm_pkg::CNT_W-1:0]         tbl_count
);

  // Pair memory and its registered read port.
  okvm_pkg::pair_t                   mem [okvm_pkg::TABLE_DEPTH];
  okvm_pkg::pair_t                   rd_data_r;
  logic                              rd_en;
  logic [okvm_pkg::IDX_W-1:0]        rd_addr;
  logic                              mem_we;
  logic [okvm_pkg::IDX_W-1:0]        mem_wa;
  okvm_pkg::pair_t                   mem_wd;

  // Sequencer state.
  okvm_pkg::bk_state_t               state_r, state_nxt;
  logic [okvm_pkg::CNT_W-1:0]        count_r, count_nxt;
  okvm_pkg::op_t                     op_kind_r, op_kind_nxt;
  logic [okvm_pkg::KEY_W-1:0]        op_key_r, op_key_nxt;
  logic [okvm_pkg::VAL_W-1:0]        op_val_r, op_val_nxt;
  logic [okvm_pkg::CNT_W-1:0]        iss_r, iss_nxt;
  logic                              dv_r, dv_nxt;
  logic [okvm_pkg::IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                              pend_valid_r, pend_valid_nxt;
  logic [okvm_pkg::VAL_W-1:0]        pend_val_r, pend_val_nxt;

  // Output register.
  logic                              out_valid_r, out_valid_nxt;
  logic [okvm_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [okvm_pkg::VAL_W-1:0]        out_val_r, out_val_nxt;
  logic [okvm_pkg::PCOUNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                              out_last_r, out_last_nxt;

  // Result produced this cycle.
  logic                              emit;
  logic [okvm_pkg::STATUS_W-1:0]     emit_status;
  logic [okvm_pkg::VAL_W-1:0]        emit_val;
  logic                              emit_last;

  logic                              advance;
  logic                              key_hit;
  logic                              pair_hit;
  logic                              scan_end;
  logic                              more;

  // The sequencer steps only when the output register can take a result.
  assign advance  = !out_valid_r || out_tready;
  assign key_hit  = dv_r && (rd_data_r.key == op_key_r);
  assign pair_hit = key_hit && (rd_data_r.value == op_val_r);
  assign more     = (iss_r < count_r);
  assign scan_end = !dv_r && !more;
  assign q_pop    = advance && (state_r == okvm_pkg::S_IDLE) && q_valid;
  assign rd_addr  = iss_r[okvm_pkg::IDX_W-1:0];
  assign rd_en    = advance && (state_r != okvm_pkg::S_IDLE) && more;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      okvm_pkg::S_IDLE: begin
        if (q_pop && (q_item.kind == okvm_pkg::OP_REMOVE ||
                      q_item.kind == okvm_pkg::OP_SEARCH)) begin
          state_nxt = okvm_pkg::S_SCAN;
        end
      end
      okvm_pkg::S_SCAN: begin
        if (advance) begin
          if (op_kind_r == okvm_pkg::OP_REMOVE && pair_hit) begin
            state_nxt = okvm_pkg::S_SHIFT;
          end else if (scan_end) begin
            state_nxt = okvm_pkg::S_IDLE;
          end
        end
      end
      okvm_pkg::S_SHIFT: begin
        if (advance && scan_end) begin
          state_nxt = okvm_pkg::S_IDLE;
        end
      end
      default: state_nxt = okvm_pkg::S_IDLE;
    endcase
  end

  // Datapath and result generation per state.
  always_comb begin
    count_nxt      = count_r;
    op_kind_nxt    = op_kind_r;
    op_key_nxt     = op_key_r;
    op_val_nxt     = op_val_r;
    iss_nxt        = iss_r;
    dv_nxt         = dv_r;
    cmp_idx_nxt    = cmp_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_val_nxt   = pend_val_r;
    mem_we         = 1'b0;
    mem_wa         = count_r[okvm_pkg::IDX_W-1:0];
    mem_wd         = '{key: q_item.key, value: q_item.value};
    emit           = 1'b0;
    emit_status    = okvm_pkg::ST_DONE;
    emit_val       = '0;
    emit_last      = 1'b1;

    // Memory read issue shared by the scan and close-up passes.
    if (rd_en) begin
      iss_nxt     = iss_r + 1'b1;
      cmp_idx_nxt = iss_r[okvm_pkg::IDX_W-1:0];
    end
    if (advance && state_r != okvm_pkg::S_IDLE) begin
      dv_nxt = more;
    end

    case (state_r)
      okvm_pkg::S_IDLE: begin
        if (q_pop) begin
          op_kind_nxt = q_item.kind;
          op_key_nxt  = q_item.key;
          op_val_nxt  = q_item.value;
          case (q_item.kind)
            okvm_pkg::OP_ADD: begin
              emit = 1'b1;
              if (count_r == okvm_pkg::CNT_W'(okvm_pkg::TABLE_DEPTH)) begin
                emit_status = okvm_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            okvm_pkg::OP_NOP: begin
              emit = 1'b1;
            end
            default: begin
              iss_nxt        = '0;
              dv_nxt         = 1'b0;
              pend_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      okvm_pkg::S_SCAN: begin
        if (advance) begin
          if (op_kind_r == okvm_pkg::OP_REMOVE) begin
            if (pair_hit) begin
              // Restart reading just past the match for the close-up.
              iss_nxt = okvm_pkg::CNT_W'(cmp_idx_r) + 1'b1;
              dv_nxt  = 1'b0;
            end else if (scan_end) begin
              emit        = 1'b1;
              emit_status = okvm_pkg::ST_NOT_FOUND;
            end
          end else begin
            // Hold one match back so the final one can carry the last flag.
            if (key_hit) begin
              if (pend_valid_r) begin
                emit        = 1'b1;
                emit_status = okvm_pkg::ST_VALUE;
                emit_val    = pend_val_r;
                emit_last   = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_val_nxt   = rd_data_r.value;
            end else if (scan_end) begin
              emit = 1'b1;
              if (pend_valid_r) begin
                emit_status = okvm_pkg::ST_VALUE;
                emit_val    = pend_val_r;
              end else begin
                emit_status = okvm_pkg::ST_NOT_FOUND;
              end
            end
          end
        end
      end
      okvm_pkg::S_SHIFT: begin
        if (advance) begin
          // Move each later pair down by one place.
          if (dv_r) begin
            mem_we = 1'b1;
            mem_wa = cmp_idx_r - 1'b1;
            mem_wd = rd_data_r;
          end
          if (scan_end) begin
            count_nxt = count_r - 1'b1;
            emit      = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register loads whenever the sequencer steps.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    if (advance) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_status_nxt = emit_status;
        out_val_nxt    = emit_val;
        out_cnt_nxt    = okvm_pkg::PCOUNT_W'(count_nxt);
        out_last_nxt   = emit_last;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= okvm_pkg::S_IDLE;
      count_r      <= '0;
      dv_r         <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      dv_r         <= dv_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_kind_r    <= op_kind_nxt;
    op_key_r     <= op_key_nxt;
    op_val_r     <= op_val_nxt;
    iss_r        <= iss_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    pend_val_r   <= pend_val_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Pair memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_val_r, out_status_r};
  assign tbl_count  = count_r;

endmodule

[rtl/ordered_key_value_multimap.sv]
// Ordered key-value multimap: a table of up to TABLE_DEPTH (16) key-value
// pairs kept in insertion order. A search, or a remove that finds no match,
// reads the pair memory one entry per cycle while the output is not stalled;
// a remove that matches closes up the later pairs right behind the match
// through the same single read port. A result that waits at the output
// stops the sequencer until it is taken. A search delivers one result per
// matching pair, oldest first, with tlast on the final one. Input
// transactions are buffered in a two-entry queue, so the input keeps
// accepting up to two transactions while a result waits to be taken. Every
// result reports the pair count after its operation. Depends on okvm_pkg,
// okvm_front and okvm_back.
`include "ordered_key_value_multimap_macros.svh"

module ordered_key_value_multimap (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] cmd, [33:2] key, [65:34] value, [71:66] zero
  input  logic [okvm_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [33:2] found_value, [38:34] pair_count, [39] zero
  output logic [okvm_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);

  logic                              q_valid;
  okvm_pkg::item_t                   q_item;
  logic                              q_pop;
  logic [okvm_pkg::CNT_W-1:0]        tbl_count;
  logic [okvm_pkg::STATUS_W-1:0]     out_status;
  logic [okvm_pkg::VAL_W-1:0]        out_found;

  // Front end: accept and classify.
  okvm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Back end: table operations and results.
  okvm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .tbl_count  (tbl_count)
  );

  assign out_status = out_tdata[okvm_pkg::STATUS_W-1:0];
  assign out_found  = out_tdata[okvm_pkg::STATUS_W +: okvm_pkg::VAL_W];

  // The pair count never exceeds the table depth.
  `OKVM_ASSERT_IMP(a_count_bound, 1'b1, tbl_count <= okvm_pkg::CNT_W'(okvm_pkg::TABLE_DEPTH), "pair count above table depth")

  // The pair count moves by at most one per cycle.
  `OKVM_ASSERT_NXT(a_count_step, 1'b1, (tbl_count == $past(tbl_count)) || (tbl_count == $past(tbl_count) + 1'b1) || (tbl_count + 1'b1 == $past(tbl_count)), "pair count jumped")

  // A table-full result only appears while the table is full.
  `OKVM_ASSERT_IMP(a_full_status, out_tvalid && out_status == okvm_pkg::ST_FULL, tbl_count == okvm_pkg::CNT_W'(okvm_pkg::TABLE_DEPTH), "full status with free entries")

  // Results without a delivered value are single and carry a zero value.
  `OKVM_ASSERT_IMP(a_plain_result, out_tvalid && out_status != okvm_pkg::ST_VALUE, out_tlast && out_found == '0, "plain result not last or value not zero")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the ordered key-value multimap stream block.
// Drives add, remove and search transactions, predicts every result in a local
// table model and compares each output transaction in order. Uses okvm_pkg.
module testbench;

  // Command code with no operation behind it; the block answers with done.
  localparam logic [okvm_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

  // Cycles without any transaction before the run is declared hung.
  localparam int HANG_LIMIT = 5000;
  // Cycles allowed after the last expected result for stray outputs.
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [okvm_pkg::STATUS_W-1:0] status;
    logic [okvm_pkg::VAL_W-1:0]    found_value;
    logic [okvm_pkg::PCOUNT_W-1:0] pair_count;
    logic                          last;
  } result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [okvm_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [okvm_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;

  // Local copy of the pair table, in insertion order.
  logic [okvm_pkg::KEY_W-1:0] table_keys[okvm_pkg::TABLE_DEPTH];
  logic [okvm_pkg::VAL_W-1:0] table_values[okvm_pkg::TABLE_DEPTH];
  int                         pair_total = 0;

  // Results still owed by the block, oldest first.
  result_t pending_results[$];

  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic [okvm_pkg::KEY_W-1:0] key_pool[6];

  ordered_key_value_multimap dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Record one owed result, stamped with the current pair count.
  function automatic void queue_result(logic [okvm_pkg::STATUS_W-1:0] status,
                                       logic [okvm_pkg::VAL_W-1:0] found_value,
                                       logic last);
    result_t r;
    r.status      = status;
    r.found_value = found_value;
    r.pair_count  = pair_total[okvm_pkg::PCOUNT_W-1:0];
    r.last        = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Update the table for one accepted command and queue its results.
  function automatic void apply_operation(logic [okvm_pkg::CMD_W-1:0] cmd,
                                          logic [okvm_pkg::KEY_W-1:0] key,
                                          logic [okvm_pkg::VAL_W-1:0] value);
    int hit;
    int last_hit;
    hit = -1;
    last_hit = -1;
    case (cmd)
      okvm_pkg::CMD_ADD: begin
        if (pair_total >= okvm_pkg::TABLE_DEPTH) begin
          queue_result(okvm_pkg::ST_FULL, '0, 1'b1);
        end else begin
          table_keys[pair_total]   = key;
          table_values[pair_total] = value;
          pair_total++;
          queue_result(okvm_pkg::ST_DONE, '0, 1'b1);
        end
      end
      okvm_pkg::CMD_REMOVE: begin
        for (int i = 0; i < pair_total; i++) begin
          if (hit < 0 && table_keys[i] == key && table_values[i] == value) hit = i;
        end
        if (hit < 0) begin
          queue_result(okvm_pkg::ST_NOT_FOUND, '0, 1'b1);
        end else begin
          // Later pairs close up so insertion order is kept.
          for (int i = hit; i + 1 < pair_total; i++) begin
            table_keys[i]   = table_keys[i + 1];
            table_values[i] = table_values[i + 1];
          end
          pair_total--;
          queue_result(okvm_pkg::ST_DONE, '0, 1'b1);
        end
      end
      okvm_pkg::CMD_SEARCH: begin
        for (int i = 0; i < pair_total; i++) begin
          if (table_keys[i] == key) last_hit = i;
        end
        if (last_hit < 0) begin
          queue_result(okvm_pkg::ST_NOT_FOUND, '0, 1'b1);
        end else begin
          for (int i = 0; i <= last_hit; i++) begin
            if (table_keys[i] == key)
              queue_result(okvm_pkg::ST_VALUE, table_values[i], i == last_hit);
          end
        end
      end
      default: begin
        queue_result(okvm_pkg::ST_DONE, '0, 1'b1);
      end
    endcase
  endfunction

  // Present one command and hold it until the block takes the transaction.
  task automatic send_item(logic [okvm_pkg::CMD_W-1:0] cmd,
                           logic [okvm_pkg::KEY_W-1:0] key,
                           logic [okvm_pkg::VAL_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(okvm_pkg::IN_DATA_W - okvm_pkg::CMD_W - okvm_pkg::KEY_W
                    - okvm_pkg::VAL_W){1'b0}}, value, key, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_operation(cmd, key, value);
  endtask

  // Stop sending until every owed result has come back.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // Result checker: each output transaction is matched against the oldest entry.
  initial begin
    result_t got;
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.status      = out_tdata[okvm_pkg::STATUS_W-1:0];
        got.found_value = out_tdata[okvm_pkg::STATUS_W +: okvm_pkg::VAL_W];
        got.pair_count  = out_tdata[okvm_pkg::STATUS_W + okvm_pkg::VAL_W +:
                                    okvm_pkg::PCOUNT_W];
        got.last        = out_tlast;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d value %h count %0d last %0b",
                     got.status, got.found_value, got.pair_count, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.found_value !== want.found_value ||
              got.pair_count !== want.pair_count || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected status %0d value %h count %0d last %0b, %s",
                       want.status, want.found_value, want.pair_count, want.last,
                       $sformatf("got status %0d value %h count %0d last %0b",
                                 got.status, got.found_value, got.pair_count, got.last));
          end
        end
      end
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Hang detector: counts cycles in which neither side moves a transaction.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("ordered_key_value_multimap test failed");
    $finish;
  end

  // Operations against an empty table, including the unused command code.
  task automatic test_empty_table();
    send_item(okvm_pkg::CMD_SEARCH, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(okvm_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Extreme keys and values, duplicate keys, and removal by exact pair.
  task automatic test_pair_edges();
    send_item(okvm_pkg::CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(okvm_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(okvm_pkg::CMD_ADD, 32'h0000_0000, 32'h0000_0000);
    send_item(okvm_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(okvm_pkg::CMD_ADD, 32'h8000_0000, 32'h0000_0000);
    send_item(okvm_pkg::CMD_SEARCH, 32'h8000_0000, 32'h0000_0000);
    send_item(okvm_pkg::CMD_REMOVE, 32'h8000_0000, 32'h0000_0000);
    send_item(okvm_pkg::CMD_REMOVE, 32'h8000_0000, 32'h0000_0001);
    send_item(okvm_pkg::CMD_SEARCH, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
  endtask

  // Fill the table, try one more add, then read back a long match list.
  task automatic test_full_table();
    while (pair_total < okvm_pkg::TABLE_DEPTH) begin
      send_item(okvm_pkg::CMD_ADD, 32'h0000_0005, $urandom);
    end
    send_item(okvm_pkg::CMD_ADD, 32'h0000_0006, 32'h0000_0006);
    wait_for_drain();
    send_item(okvm_pkg::CMD_SEARCH, 32'h0000_0005, 32'h0000_0000);
  endtask

  // Mostly well-formed traffic on a small key set, with some noise.
  task automatic test_random_mix(int count);
    int grow;
    int r;
    int pick;
    logic [okvm_pkg::CMD_W-1:0] cmd;
    logic [okvm_pkg::KEY_W-1:0] key;
    logic [okvm_pkg::VAL_W-1:0] value;
    grow = 1;
    for (int n = 0; n < count; n++) begin
      // Switch at random between growing and shrinking stretches so full and empty both occur.
      if (n % 20 == 0) grow = $urandom_range(1);
      r = $urandom_range(99);
      key = ($urandom_range(9) < 7) ? key_pool[$urandom_range(5)] : $urandom;
      value = ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom;
      if (r < 4) begin
        cmd = CMD_NOP;
      end else if (r < (grow ? 60 : 25)) begin
        cmd = okvm_pkg::CMD_ADD;
      end else if (r < (grow ? 75 : 75)) begin
        cmd = okvm_pkg::CMD_REMOVE;
        if (pair_total > 0 && $urandom_range(9) < 7) begin
          pick  = $urandom_range(pair_total - 1);
          key   = table_keys[pick];
          value = table_values[pick];
        end
      end else begin
        cmd = okvm_pkg::CMD_SEARCH;
        if (pair_total > 0 && $urandom_range(9) < 6)
          key = table_keys[$urandom_range(pair_total - 1)];
      end
      send_item(cmd, key, value);
    end
  endtask

  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = $urandom;
    key_pool[5] = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender mostly busy, receiver stalling often.
    sender_idle_pct    = 6;
    receiver_stall_pct = 47;
    test_empty_table();
    test_pair_edges();
    test_full_table();
    test_random_mix(110);
    wait_for_drain();

    // Sender idling often, receiver mostly ready.
    sender_idle_pct    = 47;
    receiver_stall_pct = 6;
    test_random_mix(115);

    // Full throughput on both sides.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_random_mix(120);
    in_tvalid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("ordered_key_value_multimap test passed");
    else
      $display("ordered_key_value_multimap test failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/okvm_pkg.sv
rtl/okvm_front.sv
rtl/okvm_back.sv
rtl/ordered_key_value_multimap.sv
tb/sv/testbench.sv
